### rtl/scl_pkg.sv
// Shared types, constants and the command lookup for the serial command line parser.
// No dependencies; imported by every other file in rtl.
`timescale 1ns / 1ps
`default_nettype none

package scl_pkg;

    localparam int LINE_BYTES    = 32;
    localparam int FILL_W        = $clog2(LINE_BYTES);
    localparam int MAX_ARGUMENTS = 8;
    localparam int ARGC_W        = $clog2(MAX_ARGUMENTS + 1);
    localparam int ARGI_W        = $clog2(MAX_ARGUMENTS);
    localparam int NAME_BYTES    = 15;
    localparam int NAMEC_W       = $clog2(NAME_BYTES);
    localparam int VALUE_W       = 31;
    localparam int MUL_W         = VALUE_W + 4;
    localparam int STATUS_W      = 3;
    localparam int CMD_W         = 3;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);

    localparam logic [VALUE_W-1:0] VALUE_CAP = {VALUE_W{1'b1}};

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_C     = 8'h63;
    localparam logic [7:0] CHAR_N     = 8'h6E;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_L     = 8'h6C;
    localparam logic [7:0] CHAR_R     = 8'h72;
    localparam logic [7:0] CHAR_Q     = 8'h71;

    // token kinds passed from front to back
    localparam logic [2:0] KIND_DIGIT = 3'd0;
    localparam logic [2:0] KIND_COMMA = 3'd1;
    localparam logic [2:0] KIND_NUL   = 3'd2;
    localparam logic [2:0] KIND_OTHER = 3'd3;
    localparam logic [2:0] KIND_CLEAR = 3'd4;
    localparam logic [2:0] KIND_END   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY_NAME = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNEXPECTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ARG_COUNT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd4;

    localparam logic [CMD_W-1:0] CMD_CN = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CA = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CR = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CQ = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } scl_tok_t;

    typedef struct packed {
        logic              hit;
        logic [CMD_W-1:0]  idx;
        logic [ARGC_W-1:0] nargs;
    } scl_cmd_t;

    // second letter of a two-letter command starting with 'c'
    function automatic scl_cmd_t cmd_lookup(input logic [7:0] second);
        scl_cmd_t r;
        r.hit   = 1'b1;
        r.idx   = CMD_CN;
        r.nargs = ARGC_W'(1);
        case (second)
            CHAR_N:  r.idx = CMD_CN;
            CHAR_A:  r.idx = CMD_CA;
            CHAR_L:  r.idx = CMD_CL;
            CHAR_R:
            begin
                r.idx   = CMD_CR;
                r.nargs = ARGC_W'(2);
            end
            CHAR_Q:  r.idx = CMD_CQ;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/serial_command_line_parser.sv
// Serial command line parser: received bytes in, one parse result per argument out.
// Input channel data_valid/data_stall carries data_byte; a transaction is taken at a
// clock edge with valid high and stall low. Output channel result_valid/result_stall
// carries status, command_index, arg_count, arg_index, arg_value and last.
// The front end classifies each byte and queues it (4 entries); the back end consumes
// one queued byte per cycle while it is not emitting results. CR or LF ends the line;
// once the terminator has left the queue the first result is loaded into the output
// register, then one per cycle while result_stall is low: a line gives one or two
// results, last marking the final.
// While results are emitted the back end stops draining the queue, so data_stall
// rises once the queue fills; a stalled result simply holds in the output register.
// A line of more than 31 bytes is dropped together with the overflowing byte.
// Reset clears the fill count, the queue, the parse state and the output valid; no line
// store is kept, so nothing needs clearing.
// Depends on scl_pkg, scl_front, scl_fifo and scl_back.
`timescale 1ns / 1ps
`default_nettype none

module serial_command_line_parser
    import scl_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 data_valid,
    output logic                      data_stall,
    input  wire logic [7:0]           data_byte,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic [STATUS_W-1:0]       status,
    output logic [CMD_W-1:0]          command_index,
    output logic [ARGC_W-1:0]         arg_count,
    output logic [ARGI_W-1:0]         arg_index,
    output logic [VALUE_W-1:0]        arg_value,
    output logic                      last
);

    scl_tok_t push_tok;
    scl_tok_t pop_tok;
    logic     push;
    logic     full;
    logic     pop;
    logic     not_empty;

    scl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .data_byte  (data_byte),
        .fifo_full  (full),
        .tok_push   (push),
        .tok        (push_tok)
    );

    scl_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_tok  (push_tok),
        .full      (full),
        .pop       (pop),
        .pop_tok   (pop_tok),
        .not_empty (not_empty)
    );

    scl_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .tok           (pop_tok),
        .tok_valid     (not_empty),
        .tok_pop       (pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .command_index (command_index),
        .arg_count     (arg_count),
        .arg_index     (arg_index),
        .arg_value     (arg_value),
        .last          (last)
    );

endmodule

`default_nettype wire

### rtl/scl_front.sv
// Front end: takes received bytes, keeps the line fill count and classifies each byte.
// Depends on scl_pkg; feeds scl_fifo.
`timescale 1ns / 1ps
`default_nettype none

module scl_front
    import scl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       data_valid,
    output logic            data_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       fifo_full,
    output logic            tok_push,
    output scl_tok_t        tok
);

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              is_term;
    logic              is_full;

    always_comb
    begin
        is_term    = (data_byte == CHAR_CR) || (data_byte == CHAR_LF);
        is_full    = (fill_reg == FILL_W'(LINE_BYTES - 1));
        data_stall = fifo_full;
        tok_push   = data_valid && !fifo_full;
        tok.data   = data_byte;

        if (is_term)
            tok.kind = KIND_END;
        else if (is_full)
            tok.kind = KIND_CLEAR;   // overflow drops the line and this byte
        else if (data_byte inside {[CHAR_ZERO:CHAR_NINE]})
            tok.kind = KIND_DIGIT;
        else if (data_byte == CHAR_COMMA)
            tok.kind = KIND_COMMA;
        else if (data_byte == CHAR_NUL)
            tok.kind = KIND_NUL;
        else
            tok.kind = KIND_OTHER;

        fill_next = fill_reg;
        if (tok_push)
        begin
            if (is_term || is_full)
                fill_next = '0;
            else
                fill_next = fill_reg + FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

endmodule

`default_nettype wire

### rtl/scl_fifo.sv
// Short token queue between front and back ends.
// Depends on scl_pkg for the token type and depth.
`timescale 1ns / 1ps
`default_nettype none

module scl_fifo
    import scl_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire scl_tok_t push_tok,
    output logic          full,
    input  wire logic     pop,
    output scl_tok_t      pop_tok,
    output logic          not_empty
);

    scl_tok_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_PTR_W:0]     count_reg;
    logic [FIFO_PTR_W:0]     count_next;
    logic                    do_push;
    logic                    do_pop;

    always_comb
    begin
        full       = (count_reg == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
        not_empty  = (count_reg != '0);
        do_push    = push && !full;
        do_pop     = pop && not_empty;
        pop_tok    = mem_reg[rd_ptr_reg];
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (FIFO_PTR_W + 1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (FIFO_PTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_tok;
    end

endmodule

`default_nettype wire

### rtl/scl_back.sv
// Back end: parses the token stream of a line and emits the result transactions.
// Depends on scl_pkg; drained from scl_fifo.
`timescale 1ns / 1ps
`default_nettype none

module scl_back
    import scl_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire scl_tok_t             tok,
    input  wire logic                 tok_valid,
    output logic                      tok_pop,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic [STATUS_W-1:0]       status,
    output logic [CMD_W-1:0]          command_index,
    output logic [ARGC_W-1:0]         arg_count,
    output logic [ARGI_W-1:0]         arg_index,
    output logic [VALUE_W-1:0]        arg_value,
    output logic                      last
);

    localparam logic S_PARSE = 1'b0;
    localparam logic S_EMIT  = 1'b1;

    logic                 state_reg,    state_next;
    logic [NAMEC_W-1:0]   name_len_reg, name_len_next;
    logic [7:0]           name0_reg,    name0_next;
    logic [7:0]           name1_reg,    name1_next;
    logic                 in_arg_reg,   in_arg_next;
    logic                 in_num_reg,   in_num_next;
    logic                 done_reg,     done_next;
    logic                 ended_reg,    ended_next;
    logic [STATUS_W-1:0]  err_reg,      err_next;
    logic [ARGC_W-1:0]    argc_reg,     argc_next;
    logic [VALUE_W-1:0]   acc_reg,      acc_next;
    logic [VALUE_W-1:0]   vals_reg [MAX_ARGUMENTS];
    logic [VALUE_W-1:0]   vals_next [MAX_ARGUMENTS];

    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [CMD_W-1:0]     res_cmd_reg,    res_cmd_next;
    logic [ARGC_W-1:0]    res_count_reg,  res_count_next;
    logic [ARGI_W-1:0]    emit_idx_reg,   emit_idx_next;

    logic                 out_valid_reg,  out_valid_next;
    logic [STATUS_W-1:0]  status_reg,     status_next;
    logic [CMD_W-1:0]     cmd_reg,        cmd_next;
    logic [ARGC_W-1:0]    count_reg,      count_next;
    logic [ARGI_W-1:0]    index_reg,      index_next;
    logic [VALUE_W-1:0]   value_reg,      value_next;
    logic                 last_reg,       last_next;

    logic                 arg_go;
    logic                 clear_parse;
    logic                 load_out;
    logic                 emit_last;
    logic [3:0]           digit;
    logic [MUL_W-1:0]     prod;
    logic [ARGC_W-1:0]    argc_fin;
    scl_cmd_t             cmd;

    always_comb
    begin
        state_next      = state_reg;
        name_len_next   = name_len_reg;
        name0_next      = name0_reg;
        name1_next      = name1_reg;
        in_arg_next     = in_arg_reg;
        in_num_next     = in_num_reg;
        done_next       = done_reg;
        ended_next      = ended_reg;
        err_next        = err_reg;
        argc_next       = argc_reg;
        acc_next        = acc_reg;
        vals_next       = vals_reg;
        res_status_next = res_status_reg;
        res_cmd_next    = res_cmd_reg;
        res_count_next  = res_count_reg;
        emit_idx_next   = emit_idx_reg;
        arg_go          = 1'b0;
        clear_parse     = 1'b0;
        argc_fin        = argc_reg;

        digit = tok.data[3:0];
        // acc * 10 + digit; acc never exceeds the cap, so MUL_W bits hold it
        prod  = (MUL_W'(acc_reg) << 3) + (MUL_W'(acc_reg) << 1) + MUL_W'(digit);
        cmd   = cmd_lookup(name1_reg);

        tok_pop = (state_reg == S_PARSE) && tok_valid;

        if (tok_pop)
        begin
            case (tok.kind)
                KIND_CLEAR:
                    clear_parse = 1'b1;
                KIND_END:
                begin
                    if (in_num_reg)
                    begin
                        vals_next[argc_reg[ARGI_W-1:0]] = acc_reg;
                        argc_fin = argc_reg + ARGC_W'(1);
                    end
                    res_cmd_next   = CMD_CN;
                    res_count_next = argc_fin;
                    if (err_reg != ST_OK)
                    begin
                        res_status_next = err_reg;
                        res_count_next  = argc_reg;
                    end
                    else if (name_len_reg == '0)
                        res_status_next = ST_EMPTY_NAME;
                    else if (name_len_reg == NAMEC_W'(2) && name0_reg == CHAR_C && cmd.hit)
                    begin
                        res_cmd_next    = cmd.idx;
                        res_status_next = (argc_fin == cmd.nargs) ? ST_OK : ST_ARG_COUNT;
                    end
                    else
                        res_status_next = ST_UNKNOWN;
                    emit_idx_next = '0;
                    clear_parse   = 1'b1;
                    state_next    = S_EMIT;
                end
                default:
                begin
                    if (err_reg == ST_OK && !ended_reg && !done_reg)
                    begin
                        if (tok.kind == KIND_NUL)
                            ended_next = 1'b1;
                        else if (in_arg_reg)
                            arg_go = 1'b1;
                        else if (tok.kind == KIND_DIGIT || tok.kind == KIND_COMMA)
                        begin
                            if (name_len_reg == '0)
                                err_next = ST_EMPTY_NAME;
                            else
                            begin
                                in_arg_next = 1'b1;
                                arg_go      = 1'b1;
                            end
                        end
                        else if (name_len_reg < NAMEC_W'(NAME_BYTES - 1))
                        begin
                            if (name_len_reg == '0)
                                name0_next = tok.data;
                            if (name_len_reg == NAMEC_W'(1))
                                name1_next = tok.data;
                            name_len_next = name_len_reg + NAMEC_W'(1);
                        end
                        else
                        begin
                            // name cut short: this byte is judged as argument text
                            in_arg_next = 1'b1;
                            arg_go      = 1'b1;
                        end
                    end
                end
            endcase
        end

        if (arg_go)
        begin
            case (tok.kind)
                KIND_DIGIT:
                begin
                    if (in_num_reg)
                        acc_next = (prod > MUL_W'(VALUE_CAP)) ? VALUE_CAP : prod[VALUE_W-1:0];
                    else
                    begin
                        acc_next    = VALUE_W'(digit);
                        in_num_next = 1'b1;
                    end
                end
                KIND_COMMA:
                begin
                    if (in_num_reg)
                    begin
                        vals_next[argc_reg[ARGI_W-1:0]] = acc_reg;
                        argc_next   = argc_reg + ARGC_W'(1);
                        in_num_next = 1'b0;
                        if (argc_reg == ARGC_W'(MAX_ARGUMENTS - 1))
                            done_next = 1'b1;
                    end
                end
                default:
                begin
                    if (in_num_reg)
                    begin
                        vals_next[argc_reg[ARGI_W-1:0]] = acc_reg;
                        argc_next   = argc_reg + ARGC_W'(1);
                        in_num_next = 1'b0;
                    end
                    err_next = ST_UNEXPECTED;
                end
            endcase
        end

        if (clear_parse)
        begin
            name_len_next = '0;
            in_arg_next   = 1'b0;
            in_num_next   = 1'b0;
            done_next     = 1'b0;
            ended_next    = 1'b0;
            err_next      = ST_OK;
            argc_next     = '0;
        end

        // result emission, one transaction per cycle through the output register while result_stall is low
        load_out  = (state_reg == S_EMIT) && (!out_valid_reg || !result_stall);
        emit_last = (res_status_reg != ST_OK) || (res_count_reg == '0)
                    || (ARGC_W'(emit_idx_reg) == res_count_reg - ARGC_W'(1));

        out_valid_next = out_valid_reg && result_stall;
        status_next    = status_reg;
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        index_next     = index_reg;
        value_next     = value_reg;
        last_next      = last_reg;

        if (load_out)
        begin
            out_valid_next = 1'b1;
            status_next    = res_status_reg;
            cmd_next       = res_cmd_reg;
            count_next     = res_count_reg;
            index_next     = emit_idx_reg;
            value_next     = (res_status_reg == ST_OK && res_count_reg != '0)
                             ? vals_reg[emit_idx_reg] : '0;
            last_next      = emit_last;
            if (emit_last)
                state_next = S_PARSE;
            else
                emit_idx_next = emit_idx_reg + ARGI_W'(1);
        end

        result_valid  = out_valid_reg;
        status        = status_reg;
        command_index = cmd_reg;
        arg_count     = count_reg;
        arg_index     = index_reg;
        arg_value     = value_reg;
        last          = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_PARSE;
            name_len_reg  <= '0;
            in_arg_reg    <= 1'b0;
            in_num_reg    <= 1'b0;
            done_reg      <= 1'b0;
            ended_reg     <= 1'b0;
            err_reg       <= ST_OK;
            argc_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            name_len_reg  <= name_len_next;
            in_arg_reg    <= in_arg_next;
            in_num_reg    <= in_num_next;
            done_reg      <= done_next;
            ended_reg     <= ended_next;
            err_reg       <= err_next;
            argc_reg      <= argc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        name0_reg      <= name0_next;
        name1_reg      <= name1_next;
        acc_reg        <= acc_next;
        vals_reg       <= vals_next;
        res_status_reg <= res_status_next;
        res_cmd_reg    <= res_cmd_next;
        res_count_reg  <= res_count_next;
        emit_idx_reg   <= emit_idx_next;
        status_reg     <= status_next;
        cmd_reg        <= cmd_next;
        count_reg      <= count_next;
        index_reg      <= index_next;
        value_reg      <= value_next;
        last_reg       <= last_next;
    end

endmodule

`default_nettype wire

### sim/serial_command_line_parser_tb.sv
// Self-checking bench for serial_command_line_parser: byte lines in, parse results out.
// Builds against the package and modules in rtl; needs nothing else.
`timescale 1ns / 1ps

module serial_command_line_parser_tb;
    import scl_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned RANDOM_BYTES  = 145;
    localparam int unsigned HOLD_OFF_LEN  = 300;
    localparam int unsigned SETTLE_CYCLES = 50;

    typedef struct packed {
        logic [STATUS_W-1:0] stat;
        logic [CMD_W-1:0]    cmd;
        logic [ARGC_W-1:0]   nargs;
        logic [ARGI_W-1:0]   arg_idx;
        logic [VALUE_W-1:0]  arg_val;
        logic                is_last;
    } parse_result_t;

    class cmd_line_scoreboard;
        logic [7:0]    line_bytes [LINE_BYTES];
        int unsigned   fill;
        parse_result_t pending_parse_results[$];
        int unsigned   mismatches;
        int unsigned   results_checked;
        int unsigned   lines_seen;

        function new();
            fill = 0;
            mismatches = 0;
            results_checked = 0;
            lines_seen = 0;
            foreach (line_bytes[i])
                line_bytes[i] = CHAR_NUL;
        endfunction

        function bit is_digit(logic [7:0] ch);
            return ch >= CHAR_ZERO && ch <= CHAR_NINE;
        endfunction

        function void queue_result(logic [STATUS_W-1:0] st, logic [CMD_W-1:0] cmd,
                                   int unsigned argc, int unsigned idx,
                                   longint unsigned val, bit fin);
            parse_result_t r;
            r.stat    = st;
            r.cmd     = cmd;
            r.nargs   = ARGC_W'(argc);
            r.arg_idx = ARGI_W'(idx);
            r.arg_val = VALUE_W'(val);
            r.is_last = fin;
            pending_parse_results.push_back(r);
        endfunction

        function void parse_stored_line();
            longint unsigned  vals [MAX_ARGUMENTS];
            longint unsigned  acc;
            int unsigned      len, pos, name_len, argc, want, n;
            logic [7:0]       first_ch, second_ch;
            logic [CMD_W-1:0] cmd;
            bit               hit;
            len = 0;
            while (len < fill && len < LINE_BYTES && line_bytes[len] != CHAR_NUL)
                len++;
            pos = 0;
            name_len = 0;
            first_ch = CHAR_NUL;
            second_ch = CHAR_NUL;
            while (pos < len && !is_digit(line_bytes[pos]) && line_bytes[pos] != CHAR_COMMA
                   && name_len < NAME_BYTES - 1)
            begin
                if (name_len == 0)
                    first_ch = line_bytes[pos];
                else if (name_len == 1)
                    second_ch = line_bytes[pos];
                name_len++;
                pos++;
            end
            if (name_len == 0)
            begin
                queue_result(ST_EMPTY_NAME, CMD_CN, 0, 0, 0, 1'b1);
                return;
            end
            argc = 0;
            while (pos < len && argc < MAX_ARGUMENTS)
            begin
                if (is_digit(line_bytes[pos]))
                begin
                    acc = 0;
                    while (pos < len && is_digit(line_bytes[pos]))
                    begin
                        acc = acc * 10 + (line_bytes[pos] - CHAR_ZERO);
                        if (acc > VALUE_CAP)
                            acc = VALUE_CAP;
                        pos++;
                    end
                    vals[argc] = acc;
                    argc++;
                end
                if (pos < len && line_bytes[pos] == CHAR_COMMA)
                    pos++;
                else if (pos < len && !is_digit(line_bytes[pos]))
                begin
                    queue_result(ST_UNEXPECTED, CMD_CN, argc, 0, 0, 1'b1);
                    return;
                end
            end
            hit = (name_len == 2) && (first_ch == CHAR_C);
            want = 1;
            cmd = CMD_CN;
            case (second_ch)
                CHAR_N:  cmd = CMD_CN;
                CHAR_A:  cmd = CMD_CA;
                CHAR_L:  cmd = CMD_CL;
                CHAR_Q:  cmd = CMD_CQ;
                CHAR_R:
                begin
                    cmd = CMD_CR;
                    want = 2;
                end
                default: hit = 1'b0;
            endcase
            if (!hit)
                queue_result(ST_UNKNOWN, CMD_CN, argc, 0, 0, 1'b1);
            else if (argc != want)
                queue_result(ST_ARG_COUNT, cmd, argc, 0, 0, 1'b1);
            else
                for (n = 0; n < argc; n++)
                    queue_result(ST_OK, cmd, argc, n, vals[n], n + 1 == argc);
        endfunction

        function void note_byte(logic [7:0] ch);
            if (ch == CHAR_CR || ch == CHAR_LF)
            begin
                lines_seen++;
                parse_stored_line();
                fill = 0;
            end
            else if (fill < LINE_BYTES - 1)
            begin
                line_bytes[fill] = ch;
                fill++;
            end
            else
                fill = 0;   // overflow: line and this byte are dropped
        endfunction

        function void compare_field(string field_name, longint unsigned exp_v,
                                    longint unsigned act_v);
            if (exp_v != act_v)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, field_name, exp_v, act_v);
            end
        endfunction

        function void check_result(parse_result_t got);
            parse_result_t want_r;
            results_checked++;
            if (pending_parse_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual status %0d value %0d",
                         $time, got.stat, got.arg_val);
                return;
            end
            want_r = pending_parse_results.pop_front();
            compare_field("status", want_r.stat, got.stat);
            compare_field("command_index", want_r.cmd, got.cmd);
            compare_field("arg_count", want_r.nargs, got.nargs);
            compare_field("arg_index", want_r.arg_idx, got.arg_idx);
            compare_field("arg_value", want_r.arg_val, got.arg_val);
            compare_field("last", want_r.is_last, got.is_last);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                data_valid = 1'b0;
    logic                data_stall;
    logic [7:0]          data_byte = 8'h00;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [CMD_W-1:0]    command_index;
    logic [ARGC_W-1:0]   arg_count;
    logic [ARGI_W-1:0]   arg_index;
    logic [VALUE_W-1:0]  arg_value;
    logic                last;

    cmd_line_scoreboard scoreboard;
    int unsigned        cycle_count = 0;
    int unsigned        bytes_sent = 0;
    int unsigned        burst_left = 0;
    bit                 hold_off_request = 1'b0;
    bit                 draining_at_end = 1'b0;

    serial_command_line_parser uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_valid    (data_valid),
        .data_stall    (data_stall),
        .data_byte     (data_byte),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .command_index (command_index),
        .arg_count     (arg_count),
        .arg_index     (arg_index),
        .arg_value     (arg_value),
        .last          (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // one byte transaction, preceded by a random gap at the start of each burst
    task automatic send_byte(input logic [7:0] ch);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                data_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        data_valid <= 1'b1;
        data_byte  <= ch;
        @(posedge clk);
        while (data_stall)
            @(posedge clk);
        scoreboard.note_byte(ch);
        bytes_sent++;
        burst_left--;
    endtask

    task automatic send_text(input string s, input logic [7:0] term);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
        send_byte(term);
    endtask

    task automatic wait_all_results();
        while (scoreboard.pending_parse_results.size() != 0)
            @(posedge clk);
    endtask

    // mostly well-formed command lines with random content, some noise and damage
    task automatic send_random_line();
        logic [7:0]  line_q[$];
        logic [7:0]  second;
        string       letters;
        int unsigned pick, want, nargs, k, digits;
        letters = "nalrq";
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            repeat ($urandom_range(1, 40))
                line_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            want = 1;
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                second = letters[$urandom_range(0, 4)];
                line_q.push_back(CHAR_C);
                line_q.push_back(second);
                if (second == CHAR_R)
                    want = 2;
            end
            else if (pick < 90)
            begin
                line_q.push_back(CHAR_C);
                line_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
            end
            else
                repeat ($urandom_range(0, 16))
                    line_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
            nargs = ($urandom_range(0, 99) < 65) ? want : $urandom_range(0, 9);
            for (k = 0; k < nargs; k++)
            begin
                if (k > 0 || $urandom_range(0, 9) == 0)
                    line_q.push_back(CHAR_COMMA);
                if ($urandom_range(0, 9) == 0)
                    line_q.push_back(CHAR_COMMA);
                pick = $urandom_range(0, 99);
                digits = (pick < 85) ? $urandom_range(1, 4) :
                         (pick < 95) ? $urandom_range(5, 9) : $urandom_range(10, 13);
                repeat (digits)
                    line_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 6)
                // 0x3A..0x7E holds neither digits nor comma
                line_q.insert($urandom_range(0, line_q.size()),
                              8'($urandom_range(8'h3A, 8'h7E)));
            else if (pick < 10)
            begin
                line_q.push_back(CHAR_NUL);
                repeat ($urandom_range(0, 5))
                    line_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end
            else if (pick < 14)
                line_q.push_back(CHAR_COMMA);
        end
        line_q.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        foreach (line_q[k])
            send_byte(line_q[k]);
    endtask

    // result side: check accepted transactions, then choose the next stall
    initial
    begin : result_sink
        int unsigned   mode, mode_left, hold_count;
        parse_result_t got;
        mode = 0;
        mode_left = 0;
        hold_count = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                got.stat    = status;
                got.cmd     = command_index;
                got.nargs   = arg_count;
                got.arg_idx = arg_index;
                got.arg_val = arg_value;
                got.is_last = last;
                scoreboard.check_result(got);
            end
            if (draining_at_end)
                result_stall <= 1'b0;
            else if (hold_count > 0)
            begin
                hold_count--;
                result_stall <= 1'b1;
            end
            else if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                hold_count = HOLD_OFF_LEN;
                result_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 99) < 30);
                    2: result_stall <= (mode_left % 4 == 0);
                    default: result_stall <= ($urandom_range(0, 99) < 75);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int          i;
        int unsigned random_lines, random_start;
        bit          failed;
        scoreboard = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("cn5", CHAR_CR);
        send_text("ca0", CHAR_LF);
        send_text("cl2147483647", CHAR_CR);
        send_text("cr1,2", CHAR_CR);
        send_text("cq99999999999", CHAR_CR);      // saturates
        send_text("", CHAR_CR);                   // empty line
        send_text(",5", CHAR_CR);
        send_text("7", CHAR_LF);
        send_text("cn", CHAR_CR);                 // no argument
        send_text("cr1", CHAR_CR);
        send_text("cx4", CHAR_CR);
        send_text("c5", CHAR_CR);
        send_text("CN5", CHAR_LF);
        send_text("cn5x", CHAR_CR);
        send_text("cn1,2,3,4,5,6,7,8,9", CHAR_CR); // ninth argument ignored
        send_text("cn1,2,3,4,5,6,7,8x", CHAR_CR);  // bad byte right after the eighth
        send_text("abcdefghijklmnopq5", CHAR_CR);  // name cut short
        send_text("abcdefghijklmn5", CHAR_CR);
        send_text("cn,,5,", CHAR_CR);
        send_text("cn7", CHAR_NUL);                // NUL ends the content
        send_text("junk", CHAR_CR);
        send_byte(CHAR_C);
        send_byte(8'hFF);
        send_text("1", CHAR_CR);
        send_text("cn5", CHAR_LF);
        send_byte(CHAR_CR);                        // terminator on an empty store
        // 31 bytes fill the store exactly
        send_text("cr1,", 8'h39);
        for (i = 0; i < 26; i++)
            send_byte(CHAR_NINE);
        send_byte(CHAR_CR);
        // 32nd byte overflows: line dropped, next line stands alone
        for (i = 0; i < 32; i++)
            send_byte(8'h62);
        send_text("cn3", CHAR_CR);

        random_start = bytes_sent;
        random_lines = 0;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            send_random_line();
            random_lines++;
            if (random_lines == 3)
                hold_off_request = 1'b1;
            if (random_lines == 8)
            begin
                data_valid <= 1'b0;
                wait_all_results();
            end
        end

        data_valid <= 1'b0;
        wait_all_results();
        draining_at_end = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        failed = scoreboard.mismatches != 0 || scoreboard.pending_parse_results.size() != 0;
        $display("Run: %0d bytes in %0d lines, %0d results checked, %0d mismatches.",
                 bytes_sent, scoreboard.lines_seen, scoreboard.results_checked,
                 scoreboard.mismatches);
        $display("Covered all commands, every status, overflow, NUL, saturation and stalls.");
        if (!failed)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
